[sv/pwm_tc_pkg.sv]
// shared types, codes and constants of the pwm timing calculator
`default_nettype none

package pwm_tc_pkg;

    localparam int          CHANNELS_DEF   = 4;
    localparam int          DEF_FREQ_HZ    = 1000;
    localparam int          DEF_DUTY_PCT   = 50;

    localparam logic [31:0] CLOCK_RESET_HZ = 32'd84000000;
    localparam logic [15:0] TICK_LIMIT     = 16'hFFFF;
    localparam logic [6:0]  DUTY_MAX       = 7'd100;
    localparam logic [63:0] PERCENT_DIV    = 64'd100;
    localparam logic [63:0] USEC_DIV       = 64'd1000000;

    // x / 100 as (x * PCT_RCP) >> PCT_SHIFT, exact for any 32-bit x
    localparam logic [31:0] PCT_RCP        = 32'h51EB851F;
    localparam int          PCT_SHIFT      = 37;
    // x / 1000000 as ((x >> 6) * USEC_RCP) >> USEC_SHIFT, exact below 2^36
    localparam logic [31:0] USEC_RCP       = 32'd1125899907;
    localparam int          USEC_PRE_SHIFT = 6;
    localparam int          USEC_X_W       = 30;
    localparam int          USEC_SHIFT     = 44;

    localparam int          DIV_W          = 64;
    localparam int          DIV_CNT_W      = $clog2(DIV_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    typedef enum logic [1:0] {
        OP_SET_FREQ  = 2'd0,
        OP_SET_DUTY  = 2'd1,
        OP_SET_WIDTH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_APPLIED   = 2'd0,
        ST_ZERO_FREQ = 2'd1,
        ST_REJECTED  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DS_PRE   = 2'd0,
        DS_Q     = 2'd1,
        DS_TICKS = 2'd2
    } div_src_t;

    typedef enum logic [2:0] {
        MS_F_PRE    = 3'd0,
        MS_Q_DUTY   = 3'd1,
        MS_TICKS    = 3'd2,
        MS_PCT_RCP  = 3'd3,
        MS_USEC_RCP = 3'd4
    } mul_src_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FREQ_CHK,
        S_PRE_WAIT,
        S_PRE_CHK,
        S_Q_START,
        S_Q_WAIT,
        S_Q_CHK,
        S_PUL_MUL,
        S_PUL_OUT,
        S_TICK_WAIT,
        S_W_MUL,
        S_W_OUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  channel;
        logic [31:0] value;
    } pwm_tc_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  channel_out;
        logic [15:0] prescaler;
        logic [15:0] period;
        logic [15:0] pulse;
    } pwm_tc_res_t;

    typedef struct packed {
        logic     capture;
        logic     load_freq;
        logic     load_duty;
        logic     div_start;
        div_src_t div_src;
        logic     load_pre;
        logic     mul_load;
        mul_src_t mul_src;
        logic     commit;
        logic     finish_reject;
        status_t  rej_code;
        logic     finish_pulse;
        logic     pulse_cap;
    } pwm_tc_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       ch_ok;
        logic       f_zero;
        logic       pre_bad;
        logic       q_bad;
        logic       div_done;
    } pwm_tc_sts_t;

endpackage

`default_nettype wire

[sv/pwm_tc_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module pwm_tc_div
    import pwm_tc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_next = DIV_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider started while running");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !start && cnt_reg == DIV_LAST) |=> done_reg)
        else $error("divider missed its done pulse");

    a_done_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("divider done while still running");

endmodule

`default_nettype wire

[sv/pwm_tc_dp.sv]
// datapath: timer state, channel tables, shared multiplier and divider
`default_nettype none

module pwm_tc_dp
    import pwm_tc_pkg::*;
#(
    parameter int CHANNELS          = CHANNELS_DEF,
    parameter int DEFAULT_FREQUENCY = DEF_FREQ_HZ,
    parameter int DEFAULT_DUTY      = DEF_DUTY_PCT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pwm_tc_req_t request,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire pwm_tc_cmd_t cmd,
    output pwm_tc_sts_t      sts,
    output pwm_tc_res_t      result
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [31:0]      clk_hz_reg;
    logic [31:0]      freq_reg [CHANNELS];
    logic [6:0]       duty_reg [CHANNELS];
    logic [15:0]      pre_reg;
    logic [15:0]      per_reg;
    logic [1:0]       op_reg;
    logic [1:0]       ch_reg;
    logic [31:0]      val_reg;
    logic [31:0]      work_f_reg;
    logic [15:0]      pre_q_reg;
    logic [63:0]      prod_reg;
    logic [1:0]       status_reg;
    logic [15:0]      pulse_reg;

    logic             ch_ok;
    logic [CH_W-1:0]  ch_idx;
    logic [6:0]       duty_sat;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] quot;
    logic             div_done;
    logic [USEC_X_W-1:0]   usec_x;
    logic [63-USEC_SHIFT:0] usec_q;
    logic [15:0]      pct_q;
    logic [15:0]      width_pulse;

    assign ch_ok    = 32'(ch_reg) < 32'(CHANNELS);
    assign ch_idx   = ch_ok ? ch_reg[CH_W-1:0] : '0;
    assign duty_sat = (val_reg > 32'(DUTY_MAX)) ? DUTY_MAX : val_reg[6:0];

    // products of 2^36 and above always cap at the period, so they saturate here
    assign usec_x = (|prod_reg[63:USEC_PRE_SHIFT+USEC_X_W]) ? '1 :
                    prod_reg[USEC_PRE_SHIFT+USEC_X_W-1:USEC_PRE_SHIFT];

    // shared multiplier operands
    always_comb
    begin
        case (cmd.mul_src)
            MS_F_PRE:
            begin
                mul_a = work_f_reg;
                mul_b = 32'(quot[15:0]) + 32'd1;
            end
            MS_Q_DUTY:
            begin
                mul_a = 32'(quot[16:0]);
                mul_b = 32'(duty_reg[ch_idx]);
            end
            MS_TICKS:
            begin
                mul_a = quot[31:0];
                mul_b = val_reg;
            end
            MS_PCT_RCP:
            begin
                mul_a = prod_reg[31:0];
                mul_b = PCT_RCP;
            end
            MS_USEC_RCP:
            begin
                mul_a = 32'(usec_x);
                mul_b = USEC_RCP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // shared divider operands
    always_comb
    begin
        case (cmd.div_src)
            DS_PRE:
            begin
                div_dividend = 64'(clk_hz_reg);
                div_divisor  = {16'b0, work_f_reg, 16'b0} + 64'(work_f_reg);
            end
            DS_Q:
            begin
                div_dividend = 64'(clk_hz_reg);
                div_divisor  = prod_reg;
            end
            DS_TICKS:
            begin
                div_dividend = 64'(clk_hz_reg);
                div_divisor  = 64'(17'(pre_reg) + 17'd1);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = 64'd1;
            end
        endcase
    end

    pwm_tc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quot)
    );

    assign pct_q       = prod_reg[PCT_SHIFT+15:PCT_SHIFT];
    assign usec_q      = prod_reg[63:USEC_SHIFT];
    assign width_pulse = (32'(usec_q) > 32'(per_reg)) ? per_reg : usec_q[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= CLOCK_RESET_HZ;
            pre_reg    <= '0;
            per_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                freq_reg[i] <= 32'(DEFAULT_FREQUENCY);
                duty_reg[i] <= 7'(DEFAULT_DUTY);
            end
        end
        else
        begin
            if (cfg_we)
            begin
                clk_hz_reg <= cfg_data;
            end
            if (cmd.load_duty)
            begin
                duty_reg[ch_idx] <= duty_sat;
            end
            if (cmd.commit)
            begin
                pre_reg          <= pre_q_reg;
                per_reg          <= quot[15:0] - 16'd1;
                freq_reg[ch_idx] <= work_f_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= request.operation;
            ch_reg  <= request.channel;
            val_reg <= request.value;
        end
        if (cmd.load_freq)
        begin
            work_f_reg <= (op_reg == OP_SET_FREQ) ? val_reg : freq_reg[ch_idx];
        end
        if (cmd.load_pre)
        begin
            pre_q_reg <= quot[15:0];
        end
        if (cmd.mul_load)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.finish_reject)
        begin
            status_reg <= cmd.rej_code;
            pulse_reg  <= '0;
        end
        else if (cmd.finish_pulse)
        begin
            status_reg <= ST_APPLIED;
            pulse_reg  <= cmd.pulse_cap ? width_pulse : pct_q;
        end
    end

    assign sts.op       = op_reg;
    assign sts.ch_ok    = ch_ok;
    assign sts.f_zero   = (work_f_reg == 32'd0);
    assign sts.pre_bad  = (|quot[63:16]) || (quot[15:0] == TICK_LIMIT);
    assign sts.q_bad    = (quot == 64'd0) || (|quot[63:16]);
    assign sts.div_done = div_done;

    assign result.status      = status_reg;
    assign result.channel_out = ch_reg;
    assign result.prescaler   = pre_reg;
    assign result.period      = per_reg;
    assign result.pulse       = pulse_reg;

endmodule

`default_nettype wire

[sv/pwm_tc_ctrl.sv]
// controller state machine sequencing the timing divisions and pulse computation
`default_nettype none

module pwm_tc_ctrl
    import pwm_tc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire pwm_tc_sts_t sts,
    output pwm_tc_cmd_t      cmd,
    output logic             busy,
    output logic             done
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!sts.ch_ok)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    case (sts.op)
                        OP_SET_FREQ, OP_SET_DUTY: state_next = S_FREQ_CHK;
                        OP_SET_WIDTH:             state_next = S_TICK_WAIT;
                        default:                  state_next = S_DONE;
                    endcase
                end
            end
            S_FREQ_CHK:
            begin
                state_next = sts.f_zero ? S_DONE : S_PRE_WAIT;
            end
            S_PRE_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_PRE_CHK;
                end
            end
            S_PRE_CHK:
            begin
                state_next = sts.pre_bad ? S_DONE : S_Q_START;
            end
            S_Q_START:
            begin
                state_next = S_Q_WAIT;
            end
            S_Q_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_Q_CHK;
                end
            end
            S_Q_CHK:
            begin
                state_next = sts.q_bad ? S_DONE : S_PUL_MUL;
            end
            S_PUL_MUL:
            begin
                state_next = S_PUL_OUT;
            end
            S_PUL_OUT:
            begin
                state_next = S_DONE;
            end
            S_TICK_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_W_MUL;
                end
            end
            S_W_MUL:
            begin
                state_next = S_W_OUT;
            end
            S_W_OUT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd.capture       = 1'b0;
        cmd.load_freq     = 1'b0;
        cmd.load_duty     = 1'b0;
        cmd.div_start     = 1'b0;
        cmd.div_src       = DS_PRE;
        cmd.load_pre      = 1'b0;
        cmd.mul_load      = 1'b0;
        cmd.mul_src       = MS_F_PRE;
        cmd.commit        = 1'b0;
        cmd.finish_reject = 1'b0;
        cmd.rej_code      = ST_REJECTED;
        cmd.finish_pulse  = 1'b0;
        cmd.pulse_cap     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = start;
            end
            S_DECODE:
            begin
                if (!sts.ch_ok)
                begin
                    cmd.finish_reject = 1'b1;
                end
                else
                begin
                    case (sts.op)
                        OP_SET_FREQ:
                        begin
                            cmd.load_freq = 1'b1;
                        end
                        OP_SET_DUTY:
                        begin
                            cmd.load_duty = 1'b1;
                            cmd.load_freq = 1'b1;
                        end
                        OP_SET_WIDTH:
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_src   = DS_TICKS;
                        end
                        default:
                        begin
                            cmd.finish_reject = 1'b1;
                        end
                    endcase
                end
            end
            S_FREQ_CHK:
            begin
                if (sts.f_zero)
                begin
                    cmd.finish_reject = 1'b1;
                    cmd.rej_code      = ST_ZERO_FREQ;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DS_PRE;
                end
            end
            S_PRE_CHK:
            begin
                if (sts.pre_bad)
                begin
                    cmd.finish_reject = 1'b1;
                end
                else
                begin
                    cmd.load_pre = 1'b1;
                    cmd.mul_load = 1'b1;
                    cmd.mul_src  = MS_F_PRE;
                end
            end
            S_Q_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DS_Q;
            end
            S_Q_CHK:
            begin
                if (sts.q_bad)
                begin
                    cmd.finish_reject = 1'b1;
                end
                else
                begin
                    cmd.commit   = 1'b1;
                    cmd.mul_load = 1'b1;
                    cmd.mul_src  = MS_Q_DUTY;
                end
            end
            S_PUL_MUL:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_src  = MS_PCT_RCP;
            end
            S_PUL_OUT:
            begin
                cmd.finish_pulse = 1'b1;
            end
            S_TICK_WAIT:
            begin
                cmd.mul_load = sts.div_done;
                cmd.mul_src  = MS_TICKS;
            end
            S_W_MUL:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_src  = MS_USEC_RCP;
            end
            S_W_OUT:
            begin
                cmd.finish_pulse = 1'b1;
                cmd.pulse_cap    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!sts.q_bad && sts.ch_ok))
        else $error("timer committed with bad period or channel");

    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider finished too early");

endmodule

`default_nettype wire

[sv/pwm_timing_calculator_unit.sv]
// top level of the pwm timing calculator
//
//  channel   ports                      direction  handshake
//  request   start, busy, request       in         taken when start && !busy
//  result    done, result               out        one-cycle strobe on done
//  config    cfg_we, cfg_data           in         written when cfg_we
//
// each division holds the shared 64-bit radix-2 divider until its done pulse
// frequency and duty items: two divisions unless rejected before the second
// pulse width items: one division; rejects go straight to done
// division by 100 and by 1000000 is a reciprocal multiply
// busy stays high from acceptance through the cycle done is high, then goes low as the unit idles
// reset clears the timer to zero and the channel tables to their defaults
`default_nettype none

module pwm_timing_calculator_unit
    import pwm_tc_pkg::*;
#(
    parameter int CHANNELS          = CHANNELS_DEF,
    parameter int DEFAULT_FREQUENCY = DEF_FREQ_HZ,
    parameter int DEFAULT_DUTY      = DEF_DUTY_PCT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire pwm_tc_req_t request,
    output logic             done,
    output pwm_tc_res_t      result,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data
);

    pwm_tc_cmd_t cmd;
    pwm_tc_sts_t sts;

    pwm_tc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pwm_tc_dp #(
        .CHANNELS          (CHANNELS),
        .DEFAULT_FREQUENCY (DEFAULT_FREQUENCY),
        .DEFAULT_DUTY      (DEFAULT_DUTY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .result   (result)
    );

endmodule

`default_nettype wire

[bench/tb_pwm_timing_calculator_unit.sv]
// testbench for the pwm timing calculator: directed and random requests checked by a scoreboard
`timescale 1ns / 1ps

module tb_pwm_timing_calculator_unit;
    import pwm_tc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    class pwm_timing_tracker;
        logic [31:0] clock_hz;
        logic [31:0] chan_freq [CHANNELS_DEF];
        logic [6:0]  chan_duty [CHANNELS_DEF];
        logic [15:0] prescaler;
        logic [15:0] period;
        pwm_tc_res_t pending_results [$];
        int          errors;
        int          reported;

        function new();
            clock_hz = CLOCK_RESET_HZ;
            for (int i = 0; i < CHANNELS_DEF; i++)
            begin
                chan_freq[i] = 32'(DEF_FREQ_HZ);
                chan_duty[i] = 7'(DEF_DUTY_PCT);
            end
            prescaler = '0;
            period    = '0;
            errors    = 0;
            reported  = 0;
        endfunction

        function bit fit_timing(input logic [31:0] freq, output logic [15:0] pre_o,
                                output logic [15:0] per_o);
            logic [63:0] pre;
            logic [63:0] quot;
            pre_o = '0;
            per_o = '0;
            pre = 64'(clock_hz) / (64'(freq) * 64'd65537);
            if (pre >= 64'(TICK_LIMIT))
                return 1'b0;
            quot = 64'(clock_hz) / (64'(freq) * (pre + 64'd1));
            if (quot == 64'd0 || quot - 64'd1 >= 64'(TICK_LIMIT))
                return 1'b0;
            pre_o = pre[15:0];
            per_o = 16'(quot - 64'd1);
            return 1'b1;
        endfunction

        function status_t retime(input int ch, input logic [31:0] freq,
                                 output logic [15:0] pulse_o);
            logic [15:0] pre_n;
            logic [15:0] per_n;
            logic [63:0] prod;
            pulse_o = '0;
            if (freq == 32'd0)
                return ST_ZERO_FREQ;
            if (!fit_timing(freq, pre_n, per_n))
                return ST_REJECTED;
            prescaler     = pre_n;
            period        = per_n;
            chan_freq[ch] = freq;
            prod = (64'(per_n) + 64'd1) * 64'(chan_duty[ch]) / PERCENT_DIV;
            pulse_o = prod[15:0];
            return ST_APPLIED;
        endfunction

        function void note_request(input pwm_tc_req_t req);
            pwm_tc_res_t res;
            status_t     st;
            logic [15:0] pul;
            logic [63:0] ticks;
            logic [63:0] width;
            int          ch;
            ch  = int'(req.channel);
            st  = ST_REJECTED;
            pul = '0;
            if (ch < CHANNELS_DEF)
            begin
                case (req.operation)
                    OP_SET_FREQ:
                        st = retime(ch, req.value, pul);
                    OP_SET_DUTY:
                    begin
                        chan_duty[ch] = (req.value > 32'(DUTY_MAX)) ? DUTY_MAX : req.value[6:0];
                        st = retime(ch, chan_freq[ch], pul);
                    end
                    OP_SET_WIDTH:
                    begin
                        ticks = 64'(clock_hz) / (64'(prescaler) + 64'd1);
                        width = ticks * 64'(req.value) / USEC_DIV;
                        if (width > 64'(period))
                            width = 64'(period);
                        pul = width[15:0];
                        st  = ST_APPLIED;
                    end
                    default:
                        st = ST_REJECTED;
                endcase
            end
            if (st != ST_APPLIED)
                pul = '0;
            res.status      = st;
            res.channel_out = req.channel;
            res.prescaler   = prescaler;
            res.period      = period;
            res.pulse       = pul;
            pending_results.push_back(res);
        endfunction

        function void check_result(input pwm_tc_res_t got);
            pwm_tc_res_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("result with no item pending: status %0d ch %0d pre %0d per %0d pulse %0d",
                             got.status, got.channel_out, got.prescaler, got.period, got.pulse);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.channel_out !== want.channel_out ||
                got.prescaler !== want.prescaler || got.period !== want.period ||
                got.pulse !== want.pulse)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("mismatch: expected status %0d ch %0d pre %0d per %0d pulse %0d",
                             want.status, want.channel_out, want.prescaler, want.period,
                             want.pulse);
                    $display("          got      status %0d ch %0d pre %0d per %0d pulse %0d",
                             got.status, got.channel_out, got.prescaler, got.period, got.pulse);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    pwm_tc_req_t request;
    logic        done;
    pwm_tc_res_t result;
    logic        cfg_we;
    logic [31:0] cfg_data;

    pwm_timing_tracker tracker = new();
    int no_gap_left = 0;

    pwm_timing_calculator_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(result);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 80)
            return $urandom_range(1, 4);
        if (r < 93)
            return $urandom_range(5, 40);
        return $urandom_range(41, 300);
    endfunction

    // frequency spread across the whole range of periods for the given clock
    function automatic logic [31:0] pick_freq(input logic [31:0] hz);
        logic [63:0] div;
        logic [63:0] f;
        div = 64'd1 + 64'($urandom >> $urandom_range(0, 31));
        f   = 64'(hz) / div;
        if (f == 64'd0)
            f = 64'($urandom_range(1, 1000));
        return f[31:0];
    endfunction

    task automatic issue(input logic [1:0] op, input logic [1:0] ch, input logic [31:0] val);
        pwm_tc_req_t req;
        int          gap;
        req.operation = op;
        req.channel   = ch;
        req.value     = val;
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        tracker.note_request(req);
        @(negedge clk);
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 24) == 0)
                no_gap_left = $urandom_range(8, 24);
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic set_timer_clock(input logic [31:0] hz);
        start <= 1'b0;
        while (tracker.pending_results.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= hz;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.clock_hz = hz;
    endtask

    task automatic random_item();
        int          r;
        logic [1:0]  ch;
        logic [31:0] val;
        r  = $urandom_range(0, 99);
        ch = 2'($urandom_range(0, 3));
        if (r < 3)
            issue(OP_UNUSED, ch, $urandom);
        else if (r < 45)
        begin
            r = $urandom_range(0, 99);
            if (r < 7)
                val = 32'd0;
            else if (r < 20)
                val = $urandom;
            else
                val = pick_freq(tracker.clock_hz);
            issue(OP_SET_FREQ, ch, val);
        end
        else if (r < 70)
        begin
            if ($urandom_range(0, 99) < 80)
                val = $urandom_range(0, 100);
            else
                val = $urandom;
            issue(OP_SET_DUTY, ch, val);
        end
        else
            issue(OP_SET_WIDTH, ch, $urandom >> $urandom_range(0, 31));
    endtask

    initial
    begin
        logic [31:0] hz;
        rst_n    = 1'b0;
        start    = 1'b0;
        request  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset clock
        issue(OP_SET_WIDTH, 2'd0, 32'd1000);
        issue(OP_SET_FREQ,  2'd0, 32'd0);
        issue(OP_SET_FREQ,  2'd1, 32'hFFFF_FFFF);
        issue(OP_SET_FREQ,  2'd2, 32'd1);
        issue(OP_SET_FREQ,  2'd3, 32'd84000000);
        issue(OP_SET_FREQ,  2'd0, 32'd20000);
        issue(OP_SET_DUTY,  2'd0, 32'd0);
        issue(OP_SET_DUTY,  2'd0, 32'd100);
        issue(OP_SET_DUTY,  2'd1, 32'd250);
        issue(OP_SET_DUTY,  2'd2, 32'hFFFF_FFFF);
        issue(OP_SET_WIDTH, 2'd0, 32'd0);
        issue(OP_SET_WIDTH, 2'd0, 32'hFFFF_FFFF);
        issue(OP_SET_WIDTH, 2'd1, 32'd10);
        issue(OP_UNUSED,    2'd2, 32'hFFFF_FFFF);
        issue(OP_UNUSED,    2'd3, 32'd0);

        // period lands exactly on the limit
        set_timer_clock(32'd65536);
        issue(OP_SET_FREQ,  2'd0, 32'd1);
        issue(OP_SET_FREQ,  2'd1, 32'd2);

        // prescaler lands exactly on the limit
        set_timer_clock(32'hFFFF_FFFF);
        issue(OP_SET_FREQ,  2'd0, 32'd1);
        issue(OP_SET_FREQ,  2'd1, 32'd2);
        issue(OP_SET_WIDTH, 2'd2, 32'hFFFF_FFFF);

        // stopped clock, duty kept although timing is rejected
        set_timer_clock(32'd0);
        issue(OP_SET_DUTY,  2'd1, 32'd10);
        issue(OP_SET_WIDTH, 2'd2, 32'd500);

        set_timer_clock(32'd1);
        issue(OP_SET_FREQ,  2'd1, 32'd1);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: hz = CLOCK_RESET_HZ;
                1: hz = $urandom;
                2: hz = 32'hFFFF_FFFF;
                3: hz = 32'd1;
                4: hz = $urandom_range(100000, 200000000);
                5: hz = 32'd0;
                6: hz = $urandom_range(1000, 10000000);
                default: hz = CLOCK_RESET_HZ;
            endcase
            set_timer_clock(hz);
            for (int n = 0; n < 50; n++)
                random_item();
        end

        start <= 1'b0;
        while (tracker.pending_results.size() != 0 || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("tb_pwm_timing_calculator_unit: done, clean");
        else
            $display("tb_pwm_timing_calculator_unit: done, errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_pwm_timing_calculator_unit: done, errors");
        $finish;
    end

endmodule

[filelist.f]
sv/pwm_tc_pkg.sv
sv/pwm_tc_div.sv
sv/pwm_tc_dp.sv
sv/pwm_tc_ctrl.sv
sv/pwm_timing_calculator_unit.sv
bench/tb_pwm_timing_calculator_unit.sv
